// File: src/prc_pkg.sv
// Shared types and constants for the polygon rectangle clipper.
// Used by prc_datapath, prc_ctrl and the polygon_rect_clipper_core top level.
`default_nettype none
package prc_pkg;

  // One clip stage for each window edge: top, bottom, left, right
  localparam int NumStages = 4;
  // Point lists: stage inputs 0..3, plus the output list after the right stage
  localparam int NumLevels = NumStages + 1;
  localparam int CfgIdxW   = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegXMin = 8'd0;
  localparam logic [CfgIdxW-1:0] RegXMax = 8'd1;
  localparam logic [CfgIdxW-1:0] RegYMin = 8'd2;
  localparam logic [CfgIdxW-1:0] RegYMax = 8'd3;

  // Stage codes
  localparam logic [1:0] StTop    = 2'd0;
  localparam logic [1:0] StBottom = 2'd1;
  localparam logic [1:0] StLeft   = 2'd2;
  localparam logic [1:0] StRight  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // take the input vertex into list 0
    logic       edge_go;   // run one clip step of a stage
    logic       closing;   // the step is the closing edge of the stage
    logic [1:0] stage;
    logic       md_start;  // start the intersection multiply-divide
    logic       push;      // push edge results into the next list
    logic       push_ix;   // push the intersection (and p2 if it is inside)
    logic       emit;      // move the head of the output list to the held vertex
    logic       fin;       // deliver the closing result item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       any;       // some list holds a point
    logic [2:0] lvl;       // deepest non-empty list
    logic       last;      // the current vertex ends the polygon
    logic       ev;        // latched edge is valid
    logic       crosses;   // latched edge crosses the boundary
    logic       both;      // latched edge lies inside
    logic       md_done;
    logic       out_free;  // output register can take a new item
  } sts_t;

endpackage
`default_nettype wire

// File: src/prc_muldiv.sv
// Iterative unsigned multiply-divide: q = floor(a * min(t, d) / d), 0 when d is 0.
// Shift-add multiply, then restoring divide; one bit per cycle. No package use.
`default_nettype none
module prc_muldiv #(
  parameter int N = 17
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] a_i,
  input  wire logic [N-1:0] t_i,
  input  wire logic [N-1:0] d_i,
  output logic      [N-1:0] q_o,
  output logic              done_o
);

  localparam int CntW = $clog2(N);
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhMul  = 2'd1;
  localparam logic [1:0] PhDiv  = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [N-1:0]    a_q, a_d, t_q, t_d, d_q, d_d;
  logic [2*N-1:0]  acc_q, acc_d;
  logic [N:0]      sh, diff;
  logic            ge;

  // Next-state logic for the multiply and divide phases
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    t_d     = t_q;
    d_d     = d_q;
    acc_d   = acc_q;
    sh      = {acc_q[2*N-1:N], acc_q[N-1]};
    diff    = sh - {1'b0, d_q};
    ge      = (sh >= {1'b0, d_q});
    unique case (phase_q)
      PhMul: begin
        acc_d = {acc_q[2*N-2:0], 1'b0} + (t_q[N-1] ? {{N{1'b0}}, a_q} : '0);
        t_d   = {t_q[N-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(N-1)) begin
          phase_d = PhDiv;
          cnt_d   = '0;
        end
      end
      PhDiv: begin
        // remainder stays below d, so one compare-subtract per bit
        acc_d = {(ge ? diff[N-1:0] : sh[N-1:0]), acc_q[N-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(N-1)) begin
          phase_d = PhIdle;
          done_d  = 1'b1;
        end
      end
      default: begin
        if (start_i) begin
          a_d     = a_i;
          t_d     = (t_i > d_i) ? d_i : t_i;
          d_d     = d_i;
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PhMul;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    t_q   <= t_d;
    d_q   <= d_d;
    acc_q <= acc_d;
  end

  assign q_o    = (d_q == '0) ? '0 : acc_q[N-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: src/prc_datapath.sv
// Clipper datapath: window registers, per-stage state, point lists, held vertex,
// output register and the intersection unit. Uses prc_pkg and prc_muldiv.
`default_nettype none
module prc_datapath #(
  parameter int CoordW = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [prc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CoordW-1:0]            cfg_data_i,
  input  wire logic [CoordW-1:0]            vertex_x_i,
  input  wire logic [CoordW-1:0]            vertex_y_i,
  input  wire logic                         vertex_last_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic      [CoordW-1:0]            out_x_o,
  output logic      [CoordW-1:0]            out_y_o,
  output logic                              out_last_o,
  output logic                              out_empty_o,
  input  wire prc_pkg::cmd_t                cmd_i,
  output prc_pkg::sts_t                     sts_o
);
  import prc_pkg::*;

  localparam int N = CoordW + 1;

  // Window registers
  logic signed [CoordW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;

  // Per-stage state
  logic signed [CoordW-1:0] first_x_q [NumStages];
  logic signed [CoordW-1:0] first_y_q [NumStages];
  logic signed [CoordW-1:0] prev_x_q  [NumStages];
  logic signed [CoordW-1:0] prev_y_q  [NumStages];
  logic [NumStages-1:0]     started_q;

  // Point lists, two entries each
  logic signed [CoordW-1:0] lst_x_q [NumLevels][2];
  logic signed [CoordW-1:0] lst_y_q [NumLevels][2];
  logic [1:0]               lst_cnt_q [NumLevels];

  // Latched edge
  logic signed [CoordW-1:0] ex0_q, ey0_q, ex1_q, ey1_q;
  logic [1:0]               es_q;
  logic                     ec0_q, ec1_q, ev_q;

  logic                     last_q, any_q;
  logic signed [CoordW-1:0] pend_x_q, pend_y_q;
  logic                     out_valid_q, out_last_q, out_empty_q;
  logic [CoordW-1:0]        out_x_q, out_y_q;

  logic [2:0]               lvl;
  logic                     any;
  logic [2:0]               sidx, nidx;
  logic [1:0]               s;
  logic signed [CoordW-1:0] hx, hy, p1x, p1y, p2x, p2y;
  logic                     c1in, c2in, out_free;

  logic                     axis_y, neg;
  logic signed [CoordW-1:0] cb, u0, u1, v0, v1;
  logic signed [N-1:0]      dv, tv, dd;
  logic [N-1:0]             adv, atv, add, mq;
  logic signed [N:0]        offs, res;
  logic signed [CoordW-1:0] ix_x, ix_y;
  logic                     md_done;

  function automatic logic inside_win(input logic [1:0] st,
                                      input logic signed [CoordW-1:0] x,
                                      input logic signed [CoordW-1:0] y,
                                      input logic signed [CoordW-1:0] x_lo,
                                      input logic signed [CoordW-1:0] x_hi,
                                      input logic signed [CoordW-1:0] y_lo,
                                      input logic signed [CoordW-1:0] y_hi);
    logic r;
    unique case (st)
      StTop:    r = (y <= y_hi);
      StBottom: r = (y >= y_lo);
      StLeft:   r = (x >= x_lo);
      default:  r = (x <= x_hi);
    endcase
    return r;
  endfunction

  function automatic logic [N-1:0] mag(input logic signed [N-1:0] v);
    return v[N-1] ? N'(-v) : N'(v);
  endfunction

  // Deepest non-empty list
  always_comb begin
    lvl = '0;
    any = 1'b0;
    for (int l = 0; l < NumLevels; l++) begin
      if (lst_cnt_q[l] != 2'd0) begin
        lvl = 3'(l);
        any = 1'b1;
      end
    end
  end

  // Endpoints of the edge being stepped
  always_comb begin
    s    = cmd_i.stage;
    sidx = {1'b0, s};
    hx   = lst_x_q[sidx][0];
    hy   = lst_y_q[sidx][0];
    p1x  = prev_x_q[s];
    p1y  = prev_y_q[s];
    p2x  = cmd_i.closing ? first_x_q[s] : hx;
    p2y  = cmd_i.closing ? first_y_q[s] : hy;
    c1in = inside_win(s, p1x, p1y, xmin_q, xmax_q, ymin_q, ymax_q);
    c2in = inside_win(s, p2x, p2y, xmin_q, xmax_q, ymin_q, ymax_q);
    nidx = {1'b0, es_q} + 3'd1;
  end

  // Intersection operands from the latched edge
  always_comb begin
    axis_y = !es_q[1];
    unique case (es_q)
      StTop:    cb = ymax_q;
      StBottom: cb = ymin_q;
      StLeft:   cb = xmin_q;
      default:  cb = xmax_q;
    endcase
    u0   = axis_y ? ey0_q : ex0_q;
    u1   = axis_y ? ey1_q : ex1_q;
    v0   = axis_y ? ex0_q : ey0_q;
    v1   = axis_y ? ex1_q : ey1_q;
    dv   = N'(v1) - N'(v0);
    tv   = N'(cb) - N'(u0);
    dd   = N'(u1) - N'(u0);
    adv  = mag(dv);
    atv  = mag(tv);
    add  = mag(dd);
    neg  = dv[N-1] ^ tv[N-1] ^ dd[N-1];
    offs = neg ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
    res  = (N+1)'(v0) + offs;
    ix_x = axis_y ? res[CoordW-1:0] : cb;
    ix_y = axis_y ? cb : res[CoordW-1:0];
  end

  prc_muldiv #(.N(N)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .a_i     (adv),
    .t_i     (atv),
    .d_i     (add),
    .q_o     (mq),
    .done_o  (md_done)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q      <= '0;
      xmax_q      <= '0;
      ymin_q      <= '0;
      ymax_q      <= '0;
      started_q   <= '0;
      ev_q        <= 1'b0;
      last_q      <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NumLevels; l++) lst_cnt_q[l] <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegXMin: xmin_q <= cfg_data_i;
          RegXMax: xmax_q <= cfg_data_i;
          RegYMin: ymin_q <= cfg_data_i;
          RegYMax: ymax_q <= cfg_data_i;
          default: ;
        endcase
      end
      // a new item overrides the handshake clear
      if ((cmd_i.emit && any_q) || cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        lst_cnt_q[0] <= 2'd1;
        last_q       <= vertex_last_i;
      end
      if (cmd_i.edge_go) begin
        ev_q <= started_q[s];
        if (cmd_i.closing) begin
          started_q[s] <= 1'b0;
        end else begin
          lst_cnt_q[sidx] <= lst_cnt_q[sidx] - 2'd1;
          started_q[s]    <= 1'b1;
        end
      end
      if (cmd_i.push) begin
        lst_cnt_q[nidx] <= (cmd_i.push_ix && ec1_q) ? 2'd2 : 2'd1;
      end
      if (cmd_i.emit) begin
        lst_cnt_q[NumLevels-1] <= lst_cnt_q[NumLevels-1] - 2'd1;
        any_q                  <= 1'b1;
      end
      if (cmd_i.fin) begin
        any_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lst_x_q[0][0] <= vertex_x_i;
      lst_y_q[0][0] <= vertex_y_i;
    end
    if (cmd_i.edge_go) begin
      ex0_q <= p1x;
      ey0_q <= p1y;
      ex1_q <= p2x;
      ey1_q <= p2y;
      ec0_q <= c1in;
      ec1_q <= c2in;
      es_q  <= s;
      if (!cmd_i.closing) begin
        prev_x_q[s]      <= hx;
        prev_y_q[s]      <= hy;
        lst_x_q[sidx][0] <= lst_x_q[sidx][1];
        lst_y_q[sidx][0] <= lst_y_q[sidx][1];
        if (!started_q[s]) begin
          first_x_q[s] <= hx;
          first_y_q[s] <= hy;
        end
      end
    end
    if (cmd_i.push) begin
      lst_x_q[nidx][0] <= cmd_i.push_ix ? ix_x : ex1_q;
      lst_y_q[nidx][0] <= cmd_i.push_ix ? ix_y : ey1_q;
      lst_x_q[nidx][1] <= ex1_q;
      lst_y_q[nidx][1] <= ey1_q;
    end
    if (cmd_i.emit) begin
      pend_x_q <= lst_x_q[NumLevels-1][0];
      pend_y_q <= lst_y_q[NumLevels-1][0];
      lst_x_q[NumLevels-1][0] <= lst_x_q[NumLevels-1][1];
      lst_y_q[NumLevels-1][0] <= lst_y_q[NumLevels-1][1];
      if (any_q) begin
        out_x_q     <= pend_x_q;
        out_y_q     <= pend_y_q;
        out_last_q  <= 1'b0;
        out_empty_q <= 1'b0;
      end
    end
    if (cmd_i.fin) begin
      out_x_q     <= any_q ? pend_x_q : '0;
      out_y_q     <= any_q ? pend_y_q : '0;
      out_last_q  <= 1'b1;
      out_empty_q <= !any_q;
    end
  end

  // Status
  always_comb begin
    sts_o.any      = any;
    sts_o.lvl      = lvl;
    sts_o.last     = last_q;
    sts_o.ev       = ev_q;
    sts_o.crosses  = ec0_q != ec1_q;
    sts_o.both     = ec0_q && ec1_q;
    sts_o.md_done  = md_done;
    sts_o.out_free = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule
`default_nettype wire

// File: src/prc_ctrl.sv
// Clipper controller: walks points depth first through the four stages,
// then the closing edges, and sequences output. Uses prc_pkg.
`default_nettype none
module prc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output prc_pkg::cmd_t       cmd_o,
  input  wire prc_pkg::sts_t  sts_i
);
  import prc_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SEval  = 3'd2;
  localparam logic [2:0] SWait  = 3'd3;
  localparam logic [2:0] SEmit  = 3'd4;
  localparam logic [2:0] SFinal = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] close_q, close_d;

  // State transitions and commands
  always_comb begin
    state_d = state_q;
    close_d = close_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          close_d    = '0;
          state_d    = SScan;
        end
      end
      SScan: begin
        priority if (sts_i.any) begin
          if (sts_i.lvl == 3'(NumStages)) begin
            state_d = SEmit;
          end else begin
            cmd_o.edge_go = 1'b1;
            cmd_o.stage   = sts_i.lvl[1:0];
            state_d       = SEval;
          end
        end else if (sts_i.last && close_q != 3'(NumStages)) begin
          cmd_o.edge_go = 1'b1;
          cmd_o.closing = 1'b1;
          cmd_o.stage   = close_q[1:0];
          close_d       = close_q + 3'd1;
          state_d       = SEval;
        end else if (sts_i.last) begin
          state_d = SFinal;
        end else begin
          state_d = SIdle;
        end
      end
      SEval: begin
        priority if (!sts_i.ev) begin
          state_d = SScan;
        end else if (sts_i.crosses) begin
          cmd_o.md_start = 1'b1;
          state_d        = SWait;
        end else begin
          cmd_o.push = sts_i.both;
          state_d    = SScan;
        end
      end
      SWait: begin
        if (sts_i.md_done) begin
          cmd_o.push    = 1'b1;
          cmd_o.push_ix = 1'b1;
          state_d       = SScan;
        end
      end
      SEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = SScan;
        end
      end
      SFinal: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      close_q <= '0;
    end else begin
      state_q <= state_d;
      close_q <= close_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);

  // One vertex in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("vertex accepted while another is in flight");

  // Intersection results only arrive while waiting for them
  a_md_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.md_done |-> (state_q == SWait))
    else $error("intersection done outside wait state");

  // Output register is never overwritten while holding an item
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.fin) |-> sts_i.out_free)
    else $error("output written while full");

  // Closing pass never runs past the last stage
  a_close_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_q <= 3'(NumStages))
    else $error("closing counter out of range");

endmodule
`default_nettype wire

// File: src/polygon_rect_clipper_core.sv
// Top level of the polygon rectangle clipper: controller plus datapath.
// Depends on prc_pkg, prc_ctrl, prc_datapath (and prc_muldiv below it).
//
//  channel  signals                                   direction
//  in       in_valid_i/in_ready_o, vertex_x/y/last_i  vertex transactions in
//  out      out_valid_o/out_ready_i, out_x/y/last/empty_o  clipped vertices out
//  cfg      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i  window writes
//
// One vertex at a time: the load, each stage step and each output vertex run
// in turn before the return to idle; a boundary crossing also waits on the
// shared iterative multiply-divide. The last vertex adds the four closing
// edges and the final item.
// Reset (rst_ni, async low) clears the window to zero, the stage started flags and the list counts.
// A stalled output holds the sequencer until the item is taken.
`default_nettype none
module polygon_rect_clipper_core #(
  parameter int CoordW = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [CoordW-1:0]            vertex_x_i,
  input  wire logic [CoordW-1:0]            vertex_y_i,
  input  wire logic                         vertex_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [CoordW-1:0]            out_x_o,
  output logic      [CoordW-1:0]            out_y_o,
  output logic                              out_last_o,
  output logic                              out_empty_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [prc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CoordW-1:0]            cfg_data_i
);
  import prc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  prc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  prc_datapath #(.CoordW(CoordW)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .vertex_last_i (vertex_last_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_last_o    (out_last_o),
    .out_empty_o   (out_empty_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
`default_nettype wire
